// ===== sv/mtg_pkg.sv =====
// mtg_pkg: shared types, command codes and fixed-point helpers for the
// mesh tangent generator. No dependencies.
`default_nettype none

package mtg_pkg;

  localparam int unsigned VERTICES_DEF = 1024;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_FACE = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         index_a;
    logic [9:0]         index_b;
    logic [9:0]         index_c;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               degenerate;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  // product / 65536, truncated toward zero
  function automatic logic signed [47:0] qtrunc(logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + (p[63] ? 64'sd65535 : 64'sd0);
    return 48'(s >>> 16);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [48:0] v);
    if (!v[48] && (|v[47:31])) begin
      return 32'sh7FFF_FFFF;
    end else if (v[48] && !(&v[47:31])) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [47:0] mag48(logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

endpackage

`default_nettype wire

// ===== sv/mtg_if.sv =====
// mtg_in_if / mtg_out_if: valid-ready channels of the tangent generator.
// Depends on mtg_pkg for the payload types.
`default_nettype none

interface mtg_in_if;
  logic             valid;
  logic             ready;
  mtg_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mtg_out_if;
  logic              valid;
  logic              ready;
  mtg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/mtg_div.sv =====
// mtg_div: 64-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on mtg_pkg for the request and response structs.
`default_nettype none

module mtg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtg_pkg::div_req_t req_i,
  output mtg_pkg::div_rsp_t rsp_o
);

  localparam int unsigned STEPS = 64;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [63:0]   rem_q;
  logic [63:0]   quo_q;
  logic [63:0]   dvs_q;

  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[63]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        cnt_q  <= CW'(STEPS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? 64'(trial - {1'b0, dvs_q}) : trial[63:0];
        quo_q <= {quo_q[62:0], fits};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== sv/mesh_tangent_generator.sv =====
// mesh_tangent_generator: a load is written as it is accepted and the block is ready again next cycle.
// Face time is set mainly by the 64-step divider (three divisions per item); read time also by the
// 32-step square root and one-bit-per-cycle rescaling.
// One item at a time; a read result waits in the output register.
// Reset clears the sequencer and output valid; vertex and accumulator RAMs are not cleared.
// Depends on mtg_pkg, mtg_if, mtg_div.
`default_nettype none

module mesh_tangent_generator #(
  parameter int unsigned VERTICES = mtg_pkg::VERTICES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtg_in_if.sink    in_i,
  mtg_out_if.source out_o
);

  localparam int unsigned AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
  } vtx_t;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [47:0] z;
  } acc_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FA, S_FB, S_FC, S_FD, S_FMUL, S_FDS, S_FDW, S_AR, S_AW,
    S_RA, S_RB, S_SCL, S_DOT, S_PROJ, S_UCHK, S_SQ, S_SQRT, S_TDS, S_TDW,
    S_BMUL, S_OUT
  } state_e;

  function automatic logic in_range(logic [9:0] idx);
    return 32'(idx) < VERTICES;
  endfunction

  function automatic logic [AW-1:0] to_addr(logic [9:0] idx);
    return AW'(32'(idx));
  endfunction

  function automatic logic signed [31:0] dsat(logic signed [31:0] p, logic signed [31:0] q);
    logic signed [48:0] t;
    t = 49'(p) - 49'(q);
    return mtg_pkg::sat32(t);
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return v[47:0];
  endfunction

  // memories
  vtx_t vmem_q [VERTICES];
  acc_t amem_q [VERTICES];
  vtx_t vrd_q;
  acc_t ard_q;

  // sequencer state
  state_e             state_q;
  logic [3:0]         mk_q;
  logic [1:0]         j_q;
  logic [9:0]         ia_q, ib_q, ic_q;
  logic               scl_u_q;
  logic signed [31:0] pa_q [5];
  logic signed [31:0] d1_q [5];
  logic signed [31:0] d2_q [5];
  logic signed [47:0] tmp_q;
  logic signed [48:0] res_q [4];
  logic signed [47:0] dir_q [3];
  logic signed [47:0] vec_q [3];
  logic signed [31:0] nrm_q [3];
  logic signed [63:0] sum_q;
  logic signed [31:0] dot_q;
  logic [63:0]        x_q, r_q, bit_q;
  logic signed [31:0] tg_q [3];
  logic signed [31:0] bt_q [3];
  logic               deg_q;
  logic signed [63:0] prod_q;
  logic               out_valid_q;
  mtg_pkg::out_item_t out_q;

  logic               accept;
  logic               load_we;
  logic               acc_we;
  logic [AW-1:0]      vaddr, aaddr, acc_waddr;
  acc_t               acc_wdata;
  logic [9:0]         corner;
  logic signed [31:0] mul_a, mul_b;
  logic [1:0]         k2;
  logic signed [47:0] qv;
  logic signed [63:0] sum_n;
  logic [47:0]        vmag [3];
  logic [47:0]        mmax;
  logic signed [47:0] vhalf [3];
  logic signed [47:0] vdbl [3];
  logic [63:0]        rb;
  logic signed [48:0] nsel;
  logic signed [48:0] nabs, dabs;
  logic signed [47:0] q48;
  logic signed [31:0] qt;
  mtg_pkg::div_req_t  div_req;
  mtg_pkg::div_rsp_t  div_rsp;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load_we    = accept && (in_i.data.cmd == mtg_pkg::CMD_LOAD) &&
                      in_range(in_i.data.index_a);
  assign acc_we     = load_we || (state_q == S_AW);

  always_comb begin
    case (j_q)
      2'd0:    corner = ia_q;
      2'd1:    corner = ib_q;
      default: corner = ic_q;
    endcase
  end

  always_comb begin
    case (state_q)
      S_FB:    vaddr = to_addr(ib_q);
      S_FC:    vaddr = to_addr(ic_q);
      default: vaddr = to_addr(ia_q);
    endcase
  end

  assign aaddr     = (state_q == S_AR) ? to_addr(corner) : to_addr(ia_q);
  assign acc_waddr = load_we ? to_addr(in_i.data.index_a) : to_addr(corner);

  always_comb begin
    if (load_we) begin
      acc_wdata = '0;
    end else begin
      acc_wdata.x = sat48(49'(ard_q.x) + 49'(dir_q[0]));
      acc_wdata.y = sat48(49'(ard_q.y) + 49'(dir_q[1]));
      acc_wdata.z = sat48(49'(ard_q.z) + 49'(dir_q[2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      vmem_q[to_addr(in_i.data.index_a)] <= '{
        pos_x:  in_i.data.pos_x,  pos_y:  in_i.data.pos_y,  pos_z: in_i.data.pos_z,
        tex_u:  in_i.data.tex_u,  tex_v:  in_i.data.tex_v,
        norm_x: in_i.data.norm_x, norm_y: in_i.data.norm_y, norm_z: in_i.data.norm_z};
    end
    vrd_q <= vmem_q[vaddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      amem_q[acc_waddr] <= acc_wdata;
    end
    ard_q <= amem_q[aaddr];
  end

  // shared multiplier operand select
  assign k2 = (mk_q[1:0] == 2'd3) ? 2'd0 : mk_q[1:0];

  always_comb begin
    mul_a = nrm_q[k2];
    mul_b = vec_q[k2][31:0];
    case (state_q)
      S_FMUL: begin
        case (mk_q)
          4'd0:    begin mul_a = d1_q[3]; mul_b = d2_q[4]; end
          4'd1:    begin mul_a = d2_q[3]; mul_b = d1_q[4]; end
          4'd2:    begin mul_a = d2_q[4]; mul_b = d1_q[0]; end
          4'd3:    begin mul_a = d1_q[4]; mul_b = d2_q[0]; end
          4'd4:    begin mul_a = d2_q[4]; mul_b = d1_q[1]; end
          4'd5:    begin mul_a = d1_q[4]; mul_b = d2_q[1]; end
          4'd6:    begin mul_a = d2_q[4]; mul_b = d1_q[2]; end
          default: begin mul_a = d1_q[4]; mul_b = d2_q[2]; end
        endcase
      end
      S_PROJ: begin
        mul_a = nrm_q[k2];
        mul_b = dot_q;
      end
      S_SQ: begin
        mul_a = vec_q[k2][31:0];
        mul_b = vec_q[k2][31:0];
      end
      S_BMUL: begin
        case (mk_q)
          4'd0:    begin mul_a = nrm_q[1]; mul_b = tg_q[2]; end
          4'd1:    begin mul_a = nrm_q[2]; mul_b = tg_q[1]; end
          4'd2:    begin mul_a = nrm_q[2]; mul_b = tg_q[0]; end
          4'd3:    begin mul_a = nrm_q[0]; mul_b = tg_q[2]; end
          4'd4:    begin mul_a = nrm_q[0]; mul_b = tg_q[1]; end
          default: begin mul_a = nrm_q[1]; mul_b = tg_q[0]; end
        endcase
      end
      default: ;
    endcase
  end

  assign qv    = mtg_pkg::qtrunc(prod_q);
  assign sum_n = sum_q + prod_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i]  = mtg_pkg::mag48(vec_q[i]);
      vhalf[i] = (vec_q[i] + (vec_q[i][47] ? 48'sd1 : 48'sd0)) >>> 1;
      vdbl[i]  = vec_q[i] <<< 1;
    end
    mmax = vmag[0];
    if (vmag[1] > mmax) mmax = vmag[1];
    if (vmag[2] > mmax) mmax = vmag[2];
  end

  assign rb = r_q + bit_q;

  // divider operands
  always_comb begin
    case (j_q)
      2'd0:    nsel = res_q[1];
      2'd1:    nsel = res_q[2];
      default: nsel = res_q[3];
    endcase
  end

  assign nabs = nsel[48] ? -nsel : nsel;
  assign dabs = res_q[0][48] ? -res_q[0] : res_q[0];

  always_comb begin
    div_req.start = (state_q == S_FDS) || (state_q == S_TDS);
    if (state_q == S_TDS) begin
      div_req.dividend = {mtg_pkg::mag48(vec_q[j_q]), 16'd0};
      div_req.divisor  = r_q;
    end else begin
      div_req.dividend = {nabs[47:0], 16'd0};
      div_req.divisor  = {15'd0, dabs};
    end
  end

  assign q48 = (|div_rsp.quotient[63:47]) ? {1'b0, {47{1'b1}}} : div_rsp.quotient[47:0];
  assign qt  = div_rsp.quotient[31:0];

  mtg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mk_q        <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= mul_a * mul_b;
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ia_q <= in_i.data.index_a;
            ib_q <= in_i.data.index_b;
            ic_q <= in_i.data.index_c;
            if (in_i.data.cmd == mtg_pkg::CMD_FACE) begin
              if (in_range(in_i.data.index_a) && in_range(in_i.data.index_b) &&
                  in_range(in_i.data.index_c)) begin
                state_q <= S_FA;
              end
            end else if (in_i.data.cmd == mtg_pkg::CMD_READ) begin
              if (in_range(in_i.data.index_a)) begin
                state_q <= S_RA;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  tg_q[i] <= '0;
                  bt_q[i] <= '0;
                end
                deg_q   <= 1'b1;
                state_q <= S_OUT;
              end
            end
          end
        end
        S_FA: state_q <= S_FB;
        S_FB: begin
          pa_q[0] <= vrd_q.pos_x;
          pa_q[1] <= vrd_q.pos_y;
          pa_q[2] <= vrd_q.pos_z;
          pa_q[3] <= vrd_q.tex_u;
          pa_q[4] <= vrd_q.tex_v;
          state_q <= S_FC;
        end
        S_FC: begin
          d1_q[0] <= dsat(vrd_q.pos_x, pa_q[0]);
          d1_q[1] <= dsat(vrd_q.pos_y, pa_q[1]);
          d1_q[2] <= dsat(vrd_q.pos_z, pa_q[2]);
          d1_q[3] <= dsat(vrd_q.tex_u, pa_q[3]);
          d1_q[4] <= dsat(vrd_q.tex_v, pa_q[4]);
          state_q <= S_FD;
        end
        S_FD: begin
          d2_q[0] <= dsat(vrd_q.pos_x, pa_q[0]);
          d2_q[1] <= dsat(vrd_q.pos_y, pa_q[1]);
          d2_q[2] <= dsat(vrd_q.pos_z, pa_q[2]);
          d2_q[3] <= dsat(vrd_q.tex_u, pa_q[3]);
          d2_q[4] <= dsat(vrd_q.tex_v, pa_q[4]);
          mk_q    <= '0;
          state_q <= S_FMUL;
        end
        S_FMUL: begin
          mk_q <= mk_q + 4'd1;
          case (mk_q)
            4'd1, 4'd3, 4'd5, 4'd7: tmp_q <= qv;
            4'd2: res_q[0] <= 49'(tmp_q) - 49'(qv);
            4'd4: res_q[1] <= 49'(tmp_q) - 49'(qv);
            4'd6: res_q[2] <= 49'(tmp_q) - 49'(qv);
            4'd8: begin
              res_q[3] <= 49'(tmp_q) - 49'(qv);
              j_q      <= '0;
              state_q  <= (res_q[0] == '0) ? S_IDLE : S_FDS;
            end
            default: ;
          endcase
        end
        S_FDS: state_q <= S_FDW;
        S_FDW: begin
          if (div_rsp.done) begin
            dir_q[j_q] <= (nsel[48] ^ res_q[0][48]) ? -q48 : q48;
            if (j_q == 2'd2) begin
              j_q     <= '0;
              state_q <= S_AR;
            end else begin
              j_q     <= j_q + 2'd1;
              state_q <= S_FDS;
            end
          end
        end
        S_AR: state_q <= S_AW;
        S_AW: begin
          if (j_q == 2'd2) begin
            state_q <= S_IDLE;
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= S_AR;
          end
        end
        S_RA: state_q <= S_RB;
        S_RB: begin
          nrm_q[0] <= vrd_q.norm_x;
          nrm_q[1] <= vrd_q.norm_y;
          nrm_q[2] <= vrd_q.norm_z;
          vec_q[0] <= ard_q.x;
          vec_q[1] <= ard_q.y;
          vec_q[2] <= ard_q.z;
          scl_u_q  <= 1'b0;
          if (ard_q == '0) begin
            for (int i = 0; i < 3; i++) begin
              tg_q[i] <= '0;
              bt_q[i] <= '0;
            end
            deg_q   <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SCL;
          end
        end
        S_SCL: begin
          mk_q  <= '0;
          sum_q <= '0;
          if (|mmax[47:29]) begin
            for (int i = 0; i < 3; i++) vec_q[i] <= vhalf[i];
          end else if (!(|mmax[47:28])) begin
            for (int i = 0; i < 3; i++) vec_q[i] <= vdbl[i];
          end else begin
            state_q <= scl_u_q ? S_SQ : S_DOT;
          end
        end
        S_DOT: begin
          mk_q <= mk_q + 4'd1;
          if (mk_q != '0) begin
            sum_q <= sum_n;
          end
          if (mk_q == 4'd3) begin
            dot_q   <= mtg_pkg::sat32(49'(mtg_pkg::qtrunc(sum_n)));
            mk_q    <= '0;
            state_q <= S_PROJ;
          end
        end
        S_PROJ: begin
          mk_q <= mk_q + 4'd1;
          case (mk_q)
            4'd1: vec_q[0] <= vec_q[0] - qv;
            4'd2: vec_q[1] <= vec_q[1] - qv;
            4'd3: begin
              vec_q[2] <= vec_q[2] - qv;
              state_q  <= S_UCHK;
            end
            default: ;
          endcase
        end
        S_UCHK: begin
          scl_u_q <= 1'b1;
          if (vec_q[0] == '0 && vec_q[1] == '0 && vec_q[2] == '0) begin
            for (int i = 0; i < 3; i++) begin
              tg_q[i] <= '0;
              bt_q[i] <= '0;
            end
            deg_q   <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SCL;
          end
        end
        S_SQ: begin
          mk_q <= mk_q + 4'd1;
          if (mk_q != '0) begin
            sum_q <= sum_n;
          end
          if (mk_q == 4'd3) begin
            x_q     <= 64'(sum_n);
            r_q     <= '0;
            bit_q   <= 64'd1 << 62;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_q == '0) begin
            j_q     <= '0;
            state_q <= S_TDS;
          end else begin
            if (x_q >= rb) begin
              x_q <= x_q - rb;
              r_q <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        S_TDS: state_q <= S_TDW;
        S_TDW: begin
          if (div_rsp.done) begin
            tg_q[j_q] <= vec_q[j_q][47] ? -qt : qt;
            if (j_q == 2'd2) begin
              mk_q    <= '0;
              state_q <= S_BMUL;
            end else begin
              j_q     <= j_q + 2'd1;
              state_q <= S_TDS;
            end
          end
        end
        S_BMUL: begin
          mk_q <= mk_q + 4'd1;
          case (mk_q)
            4'd1, 4'd3, 4'd5: tmp_q <= qv;
            4'd2: bt_q[0] <= mtg_pkg::sat32(49'(tmp_q) - 49'(qv));
            4'd4: bt_q[1] <= mtg_pkg::sat32(49'(tmp_q) - 49'(qv));
            4'd6: begin
              bt_q[2] <= mtg_pkg::sat32(49'(tmp_q) - 49'(qv));
              deg_q   <= 1'b0;
              state_q <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_q.tangent_x   <= tg_q[0];
            out_q.tangent_y   <= tg_q[1];
            out_q.tangent_z   <= tg_q[2];
            out_q.bitangent_x <= bt_q[0];
            out_q.bitangent_y <= bt_q[1];
            out_q.bitangent_z <= bt_q[2];
            out_q.degenerate  <= deg_q;
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ===== sv/mtg_checker.sv =====
// mtg_checker: port-level assertions for mesh_tangent_generator, bound to the top.
// Depends on mtg_pkg.
`default_nettype none

module mtg_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic [1:0]         in_cmd_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire mtg_pkg::out_item_t out_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result transaction changed while stalled");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cmd_i == mtg_pkg::CMD_READ |=> !in_ready_i)
    else $error("ready right after a read transaction");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cmd_i == mtg_pkg::CMD_LOAD |=> in_ready_i)
    else $error("not ready after a load transaction");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.degenerate |->
      out_data_i.tangent_x == '0 && out_data_i.tangent_y == '0 &&
      out_data_i.tangent_z == '0 && out_data_i.bitangent_x == '0 &&
      out_data_i.bitangent_y == '0 && out_data_i.bitangent_z == '0)
    else $error("degenerate result with nonzero fields");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.degenerate |->
      out_data_i.tangent_x <= 32'sd65536 && out_data_i.tangent_x >= -32'sd65536 &&
      out_data_i.tangent_y <= 32'sd65536 && out_data_i.tangent_y >= -32'sd65536 &&
      out_data_i.tangent_z <= 32'sd65536 && out_data_i.tangent_z >= -32'sd65536)
    else $error("tangent component beyond unit length");

endmodule

bind mesh_tangent_generator mtg_checker u_mtg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.data.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
